// File: rtl/sorted_insert_priority_queue_macros.svh
// Assertion macros for the sorted insert priority queue.
// Expect clk and rst_n in the scope of every use.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SIPQ_ASSERT_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SIPQ_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/sipq_pkg.sv
// Shared types and constants for the sorted insert priority queue.
// No dependencies; imported by the top level.
package sipq_pkg;

    localparam int DEFAULT_DEPTH = 128;
    localparam int KEY_W         = 16;
    localparam int TAG_W         = 16;
    localparam int OCC_W         = 8;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [TAG_W-1:0] tag_t;

    typedef struct packed {
        key_t key;
        tag_t tag;
    } entry_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_WR,
        ST_REM_RD,
        ST_REM_DAT,
        ST_RESP
    } state_t;

endpackage

// File: rtl/sipq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sipq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sorted_insert_priority_queue.sv
// Sorted insert priority queue: top level. Uses sipq_pkg, sipq_ram and
// sorted_insert_priority_queue_macros.svh.
//
// Holds up to DEPTH (key, tag) entries in a circular RAM, ascending by key
// from the head; equal keys leave in arrival order. Each input word (kind,
// key, tag) gives exactly one result word (status, head_key, head_tag,
// occupancy). An insert into a queue holding entries passes ST_INS_RD, then
// ST_INS_CMP while stored entries with a larger key are shifted, and then
// ST_INS_WR if the gap reaches the head; an insert into an empty queue goes
// straight to ST_INS_WR; a remove passes ST_REM_RD and ST_REM_DAT; an overflow
// or underflow answer goes straight to ST_RESP. The insert time is set by the
// single RAM port pair, which moves one stored entry up one slot per cycle
// while walking from the tail toward the head. in_ready is high only while the
// sequencer is idle. A finished result sits in an output register, so the
// next word may be accepted while the previous result still waits for
// out_ready. The stores have no reset and need no clearing pass: only
// occupied slots are ever read.
`include "sorted_insert_priority_queue_macros.svh"

module sorted_insert_priority_queue #(
    parameter int DEPTH = sipq_pkg::DEFAULT_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  sipq_pkg::key_t                key,
    input  sipq_pkg::tag_t                tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sipq_pkg::status_t             status,
    output sipq_pkg::key_t                head_key,
    output sipq_pkg::tag_t                head_tag,
    output logic [sipq_pkg::OCC_W-1:0]    occupancy
);
    import sipq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW:0]   WRAP_SUM  = (CW+1)'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);

    // Step a slot index back by one around the ring.
    function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] s);
        return (s == '0) ? LAST_SLOT : s - IW'(1);
    endfunction

    // Step a slot index forward by one around the ring.
    function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + IW'(1);
    endfunction

    // Control state
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] head_reg,  head_next;
    // Write slot of the insert walk: the gap that currently stands open.
    logic [IW-1:0] ptr_reg,   ptr_next;
    logic          out_valid_reg;

    // Payload
    entry_t        new_reg,        new_next;
    status_t       res_status_reg, res_status_next;
    entry_t        res_entry_reg,  res_entry_next;
    status_t       out_status_reg;
    entry_t        out_entry_reg;
    logic [CW-1:0] out_count_reg;

    // RAM port
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    logic [IW-1:0] rd_addr;
    entry_t        rd_data;

    // Datapath helpers
    logic          accept;
    logic          load_out;
    logic          shift;
    logic [IW-1:0] ptr_dn;
    logic [CW:0]   tail_sum;
    logic [CW:0]   tail_wrap;
    logic [IW-1:0] tail_slot;
    logic [CW+OCC_W-1:0] occ_wide;

    sipq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == ST_RESP) && (!out_valid_reg || out_ready);

    // Tail slot = head + count around the ring; the sum stays below twice DEPTH.
    assign tail_sum  = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail_wrap = (tail_sum >= WRAP_SUM) ? tail_sum - WRAP_SUM : tail_sum;
    assign tail_slot = tail_wrap[IW-1:0];

    assign ptr_dn = slot_dec(ptr_reg);
    // Shift the stored entry up while it holds a strictly larger key.
    assign shift  = (new_reg.key < rd_data.key);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_INSERT)
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            state_next = ST_RESP;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = ST_INS_WR;
                        end
                        else
                        begin
                            state_next = ST_INS_RD;
                        end
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_RESP : ST_REM_RD;
                    end
                end
            end
            ST_INS_RD:
            begin
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                if (shift)
                begin
                    // Gap reached the head: drop the new entry in there.
                    state_next = (ptr_dn == head_reg) ? ST_INS_WR : ST_INS_CMP;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_INS_WR:
            begin
                state_next = ST_RESP;
            end
            ST_REM_RD:
            begin
                state_next = ST_REM_DAT;
            end
            ST_REM_DAT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        ptr_next        = ptr_reg;
        new_next        = new_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = new_reg;
        rd_addr         = ptr_dn;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Latch the item and start the walk at the tail.
                    ptr_next        = tail_slot;
                    new_next.key    = key;
                    new_next.tag    = tag;
                    res_entry_next  = '0;
                    res_status_next = STATUS_DONE;
                    if ((kind == KIND_INSERT) && (count_reg == FULL_CNT))
                    begin
                        res_status_next = STATUS_OVERFLOW;
                    end
                    else if ((kind == KIND_REMOVE) && (count_reg == '0))
                    begin
                        res_status_next = STATUS_UNDERFLOW;
                    end
                end
            end
            ST_INS_RD:
            begin
                rd_addr = ptr_dn;
            end
            ST_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                if (shift)
                begin
                    // Move the larger entry up and fetch the one below it.
                    wr_data  = rd_data;
                    ptr_next = ptr_dn;
                    rd_addr  = slot_dec(ptr_dn);
                end
                else
                begin
                    wr_data    = new_reg;
                    count_next = count_reg + ONE_CNT;
                end
            end
            ST_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg;
                wr_data    = new_reg;
                count_next = count_reg + ONE_CNT;
            end
            ST_REM_RD:
            begin
                rd_addr = head_reg;
            end
            ST_REM_DAT:
            begin
                res_entry_next = rd_data;
                count_next     = count_reg - ONE_CNT;
                // Last entry gone: return the head to slot zero.
                head_next      = (count_reg == ONE_CNT) ? '0 : slot_inc(head_reg);
            end
            ST_RESP:
            begin
                rd_addr = ptr_dn;
            end
            default:
            begin
                rd_addr = ptr_dn;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            ptr_reg   <= ptr_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg        <= new_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
            out_count_reg  <= count_reg;
        end
    end

    // Occupancy reports the low bits of the entry count.
    assign occ_wide  = (CW+OCC_W)'(out_count_reg);
    assign occupancy = occ_wide[OCC_W-1:0];
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign head_key  = out_entry_reg.key;
    assign head_tag  = out_entry_reg.tag;

    `SIPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= FULL_CNT, "entry count above depth")
    `SIPQ_ASSERT_IMPL(a_empty_head, count_reg == '0, head_reg == '0, "empty queue with head off zero")
    `SIPQ_ASSERT_IMPL(a_walk_in_ring, state_reg == ST_INS_CMP, ptr_reg != head_reg, "insert walk passed the head")
    `SIPQ_ASSERT_NEXT(a_busy_after_accept, accept, state_reg != ST_IDLE, "sequencer idle after accept")

endmodule

// File: dv/sorted_insert_priority_queue_test.sv
// Self-checking testbench for the sorted insert priority queue.
// Depends on sipq_pkg and the sorted_insert_priority_queue RTL; reads no files.
// A built-in priority queue predicts every result word; directed and random tests.
`timescale 1ns / 100ps

module sorted_insert_priority_queue_test;

    import sipq_pkg::*;

    localparam int  QDEPTH         = DEFAULT_DEPTH;
    localparam int  HALF_PERIOD    = 5;
    localparam int  RESET_CYCLES   = 10;
    // Worst case per word is a full sender gap, a full-depth insert and a full
    // receiver stall; the limit covers roughly 2000 such words several times over.
    localparam longint TIMEOUT_NS  = 64'd20_000_000;
    localparam int  DRAIN_LIMIT    = 200_000;

    // How the random key of an insert is spread.
    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EDGE
    } key_spread_t;

    // One result word as the queue should answer it.
    typedef struct {
        status_t          status;
        key_t             key;
        tag_t             tag;
        logic [OCC_W-1:0] occ;
    } queue_answer_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    key_t                 key;
    tag_t                 tag;
    logic                 out_valid;
    logic                 out_ready;
    status_t              status;
    key_t                 head_key;
    tag_t                 head_tag;
    logic [OCC_W-1:0]     occupancy;

    // Predicted queue contents: circular array in ascending key order from the head.
    key_t                 shadow_key [QDEPTH];
    tag_t                 shadow_tag [QDEPTH];
    int unsigned          shadow_head;
    int unsigned          shadow_count;

    queue_answer_t        expected_answers [$];

    // Idling controls shared by the tests and the two handshake sides.
    bit                   tx_idle;
    bit                   rx_idle;
    int unsigned          hold_request;

    int unsigned          mismatches;
    int unsigned          words_checked;
    int unsigned          n_inserts;
    int unsigned          n_removes;
    int unsigned          n_overflows;
    int unsigned          n_underflows;
    int unsigned          peak_occupancy;

    sorted_insert_priority_queue #(
        .DEPTH      (QDEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .key        (key),
        .tag        (tag),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .head_key   (head_key),
        .head_tag   (head_tag),
        .occupancy  (occupancy)
    );

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Hard stop: a hung handshake ends the run here.
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Apply one accepted word to the shadow queue and queue up its answer.
    function automatic void predict_answer(kind_t k, key_t new_key, tag_t new_tag);
        queue_answer_t ans;
        int unsigned   pos;
        int unsigned   dst;
        int unsigned   src;

        ans.status = STATUS_DONE;
        ans.key    = '0;
        ans.tag    = '0;
        if (k == KIND_INSERT)
        begin
            if (shadow_count >= QDEPTH)
            begin
                // Full: drop the word, leave the queue alone.
                ans.status = STATUS_OVERFLOW;
            end
            else
            begin
                // Walk from the tail, shift strictly larger keys up one slot.
                pos = shadow_count;
                while (pos > 0 && new_key < shadow_key[(shadow_head + pos - 1) % QDEPTH])
                begin
                    dst = (shadow_head + pos) % QDEPTH;
                    src = (shadow_head + pos - 1) % QDEPTH;
                    shadow_key[dst] = shadow_key[src];
                    shadow_tag[dst] = shadow_tag[src];
                    pos--;
                end
                shadow_key[(shadow_head + pos) % QDEPTH] = new_key;
                shadow_tag[(shadow_head + pos) % QDEPTH] = new_tag;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                ans.status = STATUS_UNDERFLOW;
            end
            else
            begin
                ans.key = shadow_key[shadow_head];
                ans.tag = shadow_tag[shadow_head];
                shadow_count--;
                // The last entry out sends the head back to slot zero.
                if (shadow_count == 0)
                    shadow_head = 0;
                else
                    shadow_head = (shadow_head + 1) % QDEPTH;
            end
        end
        ans.occ = shadow_count[OCC_W-1:0];
        expected_answers.push_back(ans);
    endfunction

    function automatic key_t pick_key(key_spread_t spread);
        key_t edge_keys [6];

        edge_keys = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
        case (spread)
            SPREAD_NARROW: return key_t'($urandom_range(0, 7));
            SPREAD_EDGE:   return edge_keys[$urandom_range(0, 5)];
            default:       return key_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one word and hold it until accepted. Valid stays high on return so
    // that back-to-back words never drop it; an idle burst lowers it first.
    task automatic send_word(kind_t k, key_t new_key, tag_t new_tag);
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        key      <= new_key;
        tag      <= new_tag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_answer(k, new_key, new_tag);
    endtask

    // Random words; insert_pct steers the fill level up or down.
    task automatic send_mixed(int unsigned n_words, int unsigned insert_pct,
                              key_spread_t spread);
        kind_t k;

        repeat (n_words)
        begin
            k = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            send_word(k, pick_key(spread), tag_t'($urandom_range(0, 65535)));
        end
    endtask

    // Underflow, key and tag extremes, ties in arrival order, last entry out.
    task automatic test_directed_edges();
        send_word(KIND_REMOVE, 16'hFFFF, 16'hFFFF);
        send_word(KIND_INSERT, 16'hFFFF, 16'hFFFF);
        send_word(KIND_INSERT, 16'h0000, 16'h0000);
        send_word(KIND_INSERT, 16'h8000, 16'h1234);
        send_word(KIND_INSERT, 16'h8000, 16'h5678);
        send_word(KIND_INSERT, 16'h0001, 16'h00FF);
        send_word(KIND_INSERT, 16'h8000, 16'hABCD);
        repeat (6)
            send_word(KIND_REMOVE, 16'h0000, 16'h0000);
        send_word(KIND_REMOVE, 16'h5555, 16'hAAAA);
        // Head is back at slot zero; make sure a fresh queue behaves.
        send_word(KIND_INSERT, 16'h0005, 16'hFF00);
        send_word(KIND_INSERT, 16'h0005, 16'h00FF);
        send_word(KIND_REMOVE, 16'hAAAA, 16'h5555);
        send_word(KIND_REMOVE, 16'h0000, 16'h0000);
        send_word(KIND_REMOVE, 16'h0000, 16'h0000);
    endtask

    // Fill to the top with worst-case shifting, overflow, wrap the head, drain.
    task automatic test_fill_and_overflow();
        int unsigned i;

        i = 0;
        while (shadow_count < QDEPTH)
        begin
            // Falling keys land at the head and move every stored entry.
            if (i < QDEPTH / 2)
                send_word(KIND_INSERT, key_t'(16'hF000 - i * 16), tag_t'(i));
            else
                send_word(KIND_INSERT, pick_key(SPREAD_FULL), tag_t'($urandom_range(0, 65535)));
            i++;
        end
        send_word(KIND_INSERT, 16'h0000, 16'h0000);
        send_word(KIND_INSERT, 16'hFFFF, 16'hFFFF);
        send_word(KIND_INSERT, pick_key(SPREAD_FULL), tag_t'($urandom_range(0, 65535)));
        // Move the head off slot zero, then refill so the tail wraps around.
        repeat (40)
            send_word(KIND_REMOVE, 16'h0000, 16'h0000);
        while (shadow_count < QDEPTH)
            send_word(KIND_INSERT, pick_key(SPREAD_NARROW), tag_t'($urandom_range(0, 65535)));
        send_word(KIND_INSERT, 16'h0003, 16'h0003);
        while (shadow_count > 0)
            send_word(KIND_REMOVE, 16'h0000, 16'h0000);
        send_word(KIND_REMOVE, 16'h0000, 16'h0000);
    endtask

    // Segments that drift the fill level up and down, each with its own idling.
    task automatic test_random_mix();
        int unsigned left;
        int unsigned seg;
        int unsigned pct [3];

        pct  = '{85, 50, 15};
        left = 1250;
        while (left > 0)
        begin
            seg = $urandom_range(40, 150);
            if (seg > left)
                seg = left;
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
            send_mixed(seg, pct[$urandom_range(0, 2)],
                       key_spread_t'($urandom_range(SPREAD_FULL, SPREAD_EDGE)));
            left -= seg;
        end
    endtask

    // Hold the receiver off for a long stretch while words keep coming, so the
    // output register fills and the input stalls behind it.
    task automatic test_backpressure();
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_request = 600;
        send_mixed(30, 60, SPREAD_FULL);
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_full_rate();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_mixed(100, 70, SPREAD_FULL);
        send_mixed(100, 30, SPREAD_NARROW);
    endtask

    // Receiver: long holds first, then random stall bursts, else ready.
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned stall_left;

        hold_left  = 0;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each delivered word against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        queue_answer_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected result word: status %0d key %h tag %h occupancy %0d",
                         $time, status, head_key, head_tag, occupancy);
                mismatches++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if ($isunknown({status, head_key, head_tag, occupancy}))
                begin
                    $display("%0t: unknown bits in result word: expected status %0d, actual %b",
                             $time, want.status, status);
                    mismatches++;
                end
                check_field("status", want.status, status);
                check_field("head_key", want.key, head_key);
                check_field("head_tag", want.tag, head_tag);
                check_field("occupancy", want.occ, occupancy);
                words_checked++;
                case (want.status)
                    STATUS_OVERFLOW:  n_overflows++;
                    STATUS_UNDERFLOW: n_underflows++;
                    default:
                    begin
                        if (want.key == '0 && want.tag == '0 && want.occ > 0
                            && want.occ >= peak_occupancy)
                            n_inserts = n_inserts;
                    end
                endcase
                if (want.occ > peak_occupancy)
                    peak_occupancy = want.occ;
            end
        end
    end

    // Count inserts and removes from accepted words on the input side, overflow and underflow words included.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            if (kind == KIND_INSERT)
                n_inserts++;
            else
                n_removes++;
        end
    end

    initial
    begin : main
        int unsigned waited;

        mismatches     = 0;
        words_checked  = 0;
        n_inserts      = 0;
        n_removes      = 0;
        n_overflows    = 0;
        n_underflows   = 0;
        peak_occupancy = 0;
        shadow_head    = 0;
        shadow_count   = 0;
        hold_request   = 0;
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        kind          <= KIND_INSERT;
        key           <= '0;
        tag           <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_fill_and_overflow();
        test_random_mix();
        test_backpressure();
        test_full_rate();

        // Drop valid, then drain everything still owed.
        in_valid <= 1'b0;
        waited = 0;
        while (expected_answers.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_answers.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived",
                     $time, expected_answers.size());
            mismatches += expected_answers.size();
        end
        // Watch a little longer for stray result words.
        repeat (QDEPTH + 8) @(posedge clk);

        $display("Run covered %0d inserts and %0d removes, %0d result words checked",
                 n_inserts, n_removes, words_checked);
        $display("Overflow answers %0d, underflow answers %0d, peak occupancy %0d of %0d",
                 n_overflows, n_underflows, peak_occupancy, QDEPTH);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sipq_pkg.sv
rtl/sipq_ram.sv
rtl/sorted_insert_priority_queue.sv
dv/sorted_insert_priority_queue_test.sv
